// File: rtl/mkmc_pkg.sv
`default_nettype none
package mkmc_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int ALPHABET   = 26;

  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int SYM_W       = 5;
  localparam int CNT_W       = 16;
  localparam int TOTAL_W     = 32;
  localparam int FOUND_W     = NODE_W + CNT_W;
  localparam int CHILD_W     = NODE_W + 1;
  localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

  localparam logic [NODE_W-1:0] ROOT      = '0;
  localparam logic [NODE_W:0]   NODES_MAX = (NODE_W + 1)'(NODE_COUNT);
  localparam logic [SYM_W-1:0]  SYM_LAST  = SYM_W'(ALPHABET - 1);

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_BUILD  = 2'd2,
    FN_SCAN   = 2'd3
  } func_t;

  // Flat address of one child entry: row of the node, column of the symbol.
  function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                     input logic [SYM_W-1:0] s);
    return CHILD_AW'(node) * CHILD_AW'(ALPHABET) + CHILD_AW'(s);
  endfunction

endpackage
`default_nettype wire

// File: rtl/multi_keyword_match_counter_core.sv
`default_nettype none
// Channel   Direction  Handshake               Ports
// command   in         start high, busy low    func, symbol, last
// result    out        done, one cycle         total_found, found_now, status, last_out
//
// Busy is high from the accepting edge until the result beat is shown. A clear
// wipes the root row one entry per cycle through the single child-table port;
// reset runs the same wipe with busy high and no result beat. An insert takes a
// shorter path when the symbol is ignored or the keyword is being dropped, wipes
// the child row of a newly allocated node, and raises the keyword count of the
// end node when last marks a keyword end. A scan follows failure hops and walks
// the output chain, counting each node not yet counted; a symbol outside the
// alphabet sends the scan back to the root with no lookup. A build walks the
// root row, then each other node breadth-first, searching failure hops for its children.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module multi_keyword_match_counter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [mkmc_pkg::SYM_W-1:0]    symbol,
  input  logic                          last,
  output logic                          done,
  output logic [mkmc_pkg::TOTAL_W-1:0]  total_found,
  output logic [mkmc_pkg::CNT_W-1:0]    found_now,
  output logic                          status,
  output logic                          last_out
);
  import mkmc_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE       = 23'd1 << 0,
    S_ROW0       = 23'd1 << 1,
    S_INS_RD     = 23'd1 << 2,
    S_INS_CHK    = 23'd1 << 3,
    S_INS_ROW    = 23'd1 << 4,
    S_INS_LINK   = 23'd1 << 5,
    S_INS_END    = 23'd1 << 6,
    S_CNT_RD     = 23'd1 << 7,
    S_CNT_WR     = 23'd1 << 8,
    S_BLD_CH_RD  = 23'd1 << 9,
    S_BLD_CH_CHK = 23'd1 << 10,
    S_BLD_ADV_RD = 23'd1 << 11,
    S_BLD_ADV_CK = 23'd1 << 12,
    S_BLD_FWAIT  = 23'd1 << 13,
    S_BLD_PUSH   = 23'd1 << 14,
    S_BLD_POP    = 23'd1 << 15,
    S_BLD_POPW   = 23'd1 << 16,
    S_BLD_FAILW  = 23'd1 << 17,
    S_SC_RD      = 23'd1 << 18,
    S_SC_CHK     = 23'd1 << 19,
    S_SC_FWAIT   = 23'd1 << 20,
    S_SC_T_RD    = 23'd1 << 21,
    S_SC_T_CHK   = 23'd1 << 22
  } state_t;

  // The final step of every command is the fin flag, handled by the result step below.
  state_t state;
  logic   fin;

  func_t              func_q;
  logic [SYM_W-1:0]   sym_q;
  logic               last_q;
  logic [SYM_W-1:0]   idx;
  logic               with_result;
  logic [NODE_W:0]    nodes_used;
  logic [NODE_W-1:0]  ins_cur;
  logic [NODE_W-1:0]  scan_cur;
  logic [TOTAL_W-1:0] total;
  logic               dropping;
  logic               root_phase;
  logic [NODE_W-1:0]  node_n;
  logic [NODE_W-1:0]  fail_n;
  logic [NODE_W-1:0]  k;
  logic [NODE_W-1:0]  child_c;
  logic [NODE_W-1:0]  fres;
  logic [NODE_W-1:0]  t;
  logic [NODE_W:0]    head;
  logic [NODE_W:0]    tail;
  logic [FOUND_W-1:0] found;

  // Memory ports.
  logic [CHILD_AW-1:0] ch_addr;
  logic                ch_we, ch_re;
  logic [CHILD_W-1:0]  ch_wdata, ch_rd;
  logic [NODE_W-1:0]   cn_addr;
  logic                cn_we, cn_re;
  logic [CNT_W:0]      cn_wdata, cn_rd;
  logic [NODE_W-1:0]   fl_addr;
  logic                fl_we, fl_re;
  logic [NODE_W-1:0]   fl_wdata, fl_rd;
  logic [NODE_W-1:0]   q_addr;
  logic                q_we, q_re;
  logic [NODE_W-1:0]   q_wdata, q_rd;

  logic               ch_valid;
  logic [NODE_W-1:0]  ch_node;
  logic [CNT_W-1:0]   cnt_val;
  logic               cnt_used;
  logic [CNT_W-1:0]   cnt_inc;
  logic [TOTAL_W:0]   sum;
  logic               sym_ok;

  assign ch_valid = ch_rd[NODE_W];
  assign ch_node  = ch_rd[NODE_W-1:0];
  assign cnt_used = cn_rd[CNT_W];
  assign cnt_val  = cn_rd[CNT_W-1:0];
  assign cnt_inc  = (cnt_val == {CNT_W{1'b1}}) ? cnt_val : cnt_val + CNT_W'(1);
  assign sum      = {1'b0, total} + (TOTAL_W + 1)'(found);
  assign sym_ok   = int'(symbol) < ALPHABET;
  assign busy     = (state != S_IDLE) || fin;

  // Memory control. Reads issued in one state return data in the next.
  always_comb begin
    ch_addr  = '0;
    ch_we    = 1'b0;
    ch_re    = 1'b0;
    ch_wdata = '0;
    cn_addr  = '0;
    cn_we    = 1'b0;
    cn_re    = 1'b0;
    cn_wdata = '0;
    fl_addr  = '0;
    fl_we    = 1'b0;
    fl_re    = 1'b0;
    fl_wdata = '0;
    q_addr   = '0;
    q_we     = 1'b0;
    q_re     = 1'b0;
    q_wdata  = '0;
    case (state)
      S_ROW0: begin
        ch_addr = child_addr(ROOT, idx);
        ch_we   = 1'b1;
        cn_addr = ROOT;
        cn_we   = 1'b1;
        fl_addr = ROOT;
        fl_we   = 1'b1;
      end
      S_INS_RD: begin
        ch_addr = child_addr(ins_cur, sym_q);
        ch_re   = 1'b1;
      end
      S_INS_ROW: begin
        ch_addr = child_addr(nodes_used[NODE_W-1:0], idx);
        ch_we   = 1'b1;
        cn_addr = nodes_used[NODE_W-1:0];
        cn_we   = 1'b1;
        fl_addr = nodes_used[NODE_W-1:0];
        fl_we   = 1'b1;
      end
      S_INS_LINK: begin
        ch_addr  = child_addr(ins_cur, sym_q);
        ch_we    = 1'b1;
        ch_wdata = {1'b1, nodes_used[NODE_W-1:0]};
      end
      S_CNT_RD: begin
        cn_addr = ins_cur;
        cn_re   = 1'b1;
      end
      S_CNT_WR: begin
        cn_addr  = ins_cur;
        cn_we    = 1'b1;
        cn_wdata = {cnt_used, cnt_inc};
      end
      S_BLD_CH_RD: begin
        ch_addr = child_addr(node_n, idx);
        ch_re   = 1'b1;
      end
      S_BLD_ADV_RD: begin
        ch_addr = child_addr(k, idx);
        ch_re   = 1'b1;
      end
      S_BLD_ADV_CK: begin
        fl_addr = k;
        fl_re   = 1'b1;
      end
      S_BLD_PUSH: begin
        fl_addr  = child_c;
        fl_we    = 1'b1;
        fl_wdata = fres;
        q_addr   = tail[NODE_W-1:0];
        q_we     = 1'b1;
        q_wdata  = child_c;
      end
      S_BLD_POP: begin
        q_addr = head[NODE_W-1:0];
        q_re   = 1'b1;
      end
      S_BLD_POPW: begin
        fl_addr = q_rd;
        fl_re   = 1'b1;
      end
      S_SC_RD: begin
        ch_addr = child_addr(k, sym_q);
        ch_re   = 1'b1;
      end
      S_SC_CHK: begin
        fl_addr = k;
        fl_re   = 1'b1;
      end
      S_SC_T_RD: begin
        cn_addr = t;
        cn_re   = 1'b1;
        fl_addr = t;
        fl_re   = 1'b1;
      end
      S_SC_T_CHK: begin
        cn_addr  = t;
        cn_we    = !cnt_used;
        cn_wdata = {1'b1, cnt_val};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_ROW0;
      fin         <= 1'b0;
      idx         <= '0;
      with_result <= 1'b0;
      nodes_used  <= (NODE_W + 1)'(1);
      ins_cur     <= ROOT;
      scan_cur    <= ROOT;
      total       <= '0;
      dropping    <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      // The result step, in the cycle after the last working state.
      if (fin) begin
        done        <= 1'b1;
        last_out    <= last_q;
        total_found <= total;
        found_now   <= '0;
        status      <= 1'b0;
        case (func_q)
          FN_INSERT: begin
            status <= dropping;
            if (last_q) begin
              ins_cur  <= ROOT;
              dropping <= 1'b0;
            end
          end
          FN_SCAN: begin
            total       <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            total_found <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            found_now   <= (|found[FOUND_W-1:CNT_W]) ? {CNT_W{1'b1}} : found[CNT_W-1:0];
            if (last_q) begin
              scan_cur <= ROOT;
            end
          end
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            func_q <= func_t'(func);
            sym_q  <= symbol;
            last_q <= last;
            found  <= '0;
            case (func_t'(func))
              FN_CLEAR: begin
                idx         <= '0;
                with_result <= 1'b1;
                state       <= S_ROW0;
              end
              FN_INSERT: begin
                if (!dropping && sym_ok) begin
                  state <= S_INS_RD;
                end else begin
                  state <= S_INS_END;
                end
              end
              FN_BUILD: begin
                node_n     <= ROOT;
                root_phase <= 1'b1;
                idx        <= '0;
                head       <= '0;
                tail       <= '0;
                state      <= S_BLD_CH_RD;
              end
              default: begin
                if (sym_ok) begin
                  k     <= scan_cur;
                  state <= S_SC_RD;
                end else begin
                  scan_cur <= ROOT;
                  fin      <= 1'b1;
                end
              end
            endcase
          end
        end
        S_ROW0: begin
          if (idx == SYM_LAST) begin
            nodes_used <= (NODE_W + 1)'(1);
            ins_cur    <= ROOT;
            scan_cur   <= ROOT;
            total      <= '0;
            dropping   <= 1'b0;
            fin        <= with_result;
            state      <= S_IDLE;
          end else begin
            idx <= idx + SYM_W'(1);
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK: begin
          if (ch_valid) begin
            ins_cur <= ch_node;
            state   <= S_INS_END;
          end else if (nodes_used >= NODES_MAX) begin
            dropping <= 1'b1;
            state    <= S_INS_END;
          end else begin
            idx   <= '0;
            state <= S_INS_ROW;
          end
        end
        S_INS_ROW: begin
          if (idx == SYM_LAST) begin
            state <= S_INS_LINK;
          end else begin
            idx <= idx + SYM_W'(1);
          end
        end
        S_INS_LINK: begin
          ins_cur    <= nodes_used[NODE_W-1:0];
          nodes_used <= nodes_used + (NODE_W + 1)'(1);
          state      <= S_INS_END;
        end
        S_INS_END: begin
          if (last_q && !dropping) begin
            state <= S_CNT_RD;
          end else begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CNT_RD: state <= S_CNT_WR;
        S_CNT_WR: begin
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        S_BLD_CH_RD: state <= S_BLD_CH_CHK;
        S_BLD_CH_CHK: begin
          if (ch_valid) begin
            child_c <= ch_node;
            if (root_phase) begin
              fres  <= ROOT;
              state <= S_BLD_PUSH;
            end else begin
              k     <= fail_n;
              state <= S_BLD_ADV_RD;
            end
          end else if (idx == SYM_LAST) begin
            state <= S_BLD_POP;
          end else begin
            idx   <= idx + SYM_W'(1);
            state <= S_BLD_CH_RD;
          end
        end
        S_BLD_ADV_RD: state <= S_BLD_ADV_CK;
        S_BLD_ADV_CK: begin
          if (ch_valid) begin
            fres  <= ch_node;
            state <= S_BLD_PUSH;
          end else if (k == ROOT) begin
            fres  <= ROOT;
            state <= S_BLD_PUSH;
          end else begin
            state <= S_BLD_FWAIT;
          end
        end
        S_BLD_FWAIT: begin
          k     <= fl_rd;
          state <= S_BLD_ADV_RD;
        end
        S_BLD_PUSH: begin
          tail <= tail + (NODE_W + 1)'(1);
          if (idx == SYM_LAST) begin
            state <= S_BLD_POP;
          end else begin
            idx   <= idx + SYM_W'(1);
            state <= S_BLD_CH_RD;
          end
        end
        S_BLD_POP: begin
          if (head < tail) begin
            head  <= head + (NODE_W + 1)'(1);
            state <= S_BLD_POPW;
          end else begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_BLD_POPW: begin
          node_n <= q_rd;
          state  <= S_BLD_FAILW;
        end
        S_BLD_FAILW: begin
          fail_n     <= fl_rd;
          root_phase <= 1'b0;
          idx        <= '0;
          state      <= S_BLD_CH_RD;
        end
        S_SC_RD: state <= S_SC_CHK;
        S_SC_CHK: begin
          if (ch_valid) begin
            t        <= ch_node;
            scan_cur <= ch_node;
            state    <= S_SC_T_RD;
          end else if (k == ROOT) begin
            t        <= ROOT;
            scan_cur <= ROOT;
            state    <= S_SC_T_RD;
          end else begin
            state <= S_SC_FWAIT;
          end
        end
        S_SC_FWAIT: begin
          k     <= fl_rd;
          state <= S_SC_RD;
        end
        S_SC_T_RD: state <= S_SC_T_CHK;
        S_SC_T_CHK: begin
          if (cnt_used) begin
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            found <= found + FOUND_W'(cnt_val);
            t     <= fl_rd;
            state <= S_SC_T_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Child table: valid bit and node index per node and symbol.
  mkmc_ram #(.WIDTH(CHILD_W), .DEPTH(CHILD_DEPTH)) u_child (
    .clk(clk), .addr(ch_addr), .we(ch_we), .wdata(ch_wdata), .re(ch_re), .rdata(ch_rd)
  );

  // Per-node consumed mark and keyword count.
  mkmc_ram #(.WIDTH(CNT_W + 1), .DEPTH(NODE_COUNT)) u_count (
    .clk(clk), .addr(cn_addr), .we(cn_we), .wdata(cn_wdata), .re(cn_re), .rdata(cn_rd)
  );

  // Per-node failure link.
  mkmc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_fail (
    .clk(clk), .addr(fl_addr), .we(fl_we), .wdata(fl_wdata), .re(fl_re), .rdata(fl_rd)
  );

  // Breadth-first work queue of the build command.
  mkmc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_queue (
    .clk(clk), .addr(q_addr), .we(q_we), .wdata(q_wdata), .re(q_re), .rdata(q_rd)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_nodes_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_used >= (NODE_W + 1)'(1)) && (nodes_used <= NODES_MAX))
    else $error("node count out of range");

  a_status_insert: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (func_q == FN_INSERT))
    else $error("status raised on a command other than insert");

endmodule
`default_nettype wire

// File: rtl/mkmc_ram.sv
`default_nettype none
module mkmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire
